// ----- sv/sld_pkg.sv -----
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CODE_W  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [COUNT_W-1:0] HDR_BYTES = 9'd3;
    localparam logic [COUNT_W-1:0] POS_CMD   = 9'd1;
    localparam logic [COUNT_W-1:0] POS_LEN   = 9'd2;
    localparam logic [COUNT_W-1:0] POS_SYNC  = 9'd0;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    typedef enum logic [CODE_W-1:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_SYNC = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_SIZE     = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_cmd;
        logic [BYTE_W-1:0] frame_length;
        t_status           status_code;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

// ----- sv/sld_in_if.sv -----
// ----------------------------------------------------------------------------
// sld_in_if
// Received-byte channel: valid/ready handshake with byte and last flag.
// ----------------------------------------------------------------------------
interface sld_in_if;
    logic                       valid;
    logic                       ready;
    logic [sld_pkg::BYTE_W-1:0] rx_byte;
    logic                       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ----- sv/sld_out_if.sv -----
// ----------------------------------------------------------------------------
// sld_out_if
// Result channel: payload byte words and end-of-buffer status words.
// ----------------------------------------------------------------------------
interface sld_out_if;
    logic                       valid;
    logic                       ready;
    logic                       result_kind;
    logic [sld_pkg::BYTE_W-1:0] payload_byte;
    logic [sld_pkg::BYTE_W-1:0] payload_index;
    logic [sld_pkg::BYTE_W-1:0] frame_cmd;
    logic [sld_pkg::BYTE_W-1:0] frame_length;
    logic [sld_pkg::CODE_W-1:0] status_code;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_cmd, output frame_length,
                    output status_code, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input frame_cmd, input frame_length,
                    input status_code, output ready);
endinterface

// ----- sv/sld_core.sv -----
// ----------------------------------------------------------------------------
// sld_core
// Frame state and per-byte decode; yields at most one result word per byte.
// ----------------------------------------------------------------------------
module sld_core #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sld_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic                       i_accept,
    input  logic [sld_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                       i_rx_last,
    output sld_pkg::t_push             o_push
);

    localparam logic [sld_pkg::BYTE_W-1:0] MaxLen = sld_pkg::BYTE_W'(MAX_PAYLOAD);

    logic [sld_pkg::BYTE_W-1:0]  r_sync_value;
    logic [sld_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic                        r_sync_ok, n_sync_ok;
    logic [sld_pkg::BYTE_W-1:0]  r_cmd, n_cmd;
    logic [sld_pkg::BYTE_W-1:0]  r_len, n_len;
    logic [sld_pkg::BYTE_W-1:0]  r_xor, n_xor;

    logic [sld_pkg::COUNT_W-1:0] len_limit;
    logic [sld_pkg::COUNT_W-1:0] pay_index;
    logic                        len_ok;
    logic                        in_payload;
    sld_pkg::t_status            code;

    always_comb begin
        n_sync_ok = r_sync_ok;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_xor     = r_xor;
        if (r_byte_count == sld_pkg::POS_SYNC) begin
            n_sync_ok = (i_rx_byte == r_sync_value);
        end else if (r_byte_count == sld_pkg::POS_CMD) begin
            n_cmd = i_rx_byte;
            n_xor = r_xor ^ i_rx_byte;
        end else if (r_byte_count == sld_pkg::POS_LEN) begin
            n_len = i_rx_byte;
            n_xor = r_xor ^ i_rx_byte;
        end

        len_ok     = (n_len <= MaxLen);
        len_limit  = sld_pkg::HDR_BYTES + sld_pkg::COUNT_W'(n_len);
        in_payload = (r_byte_count >= sld_pkg::HDR_BYTES) && (r_byte_count < len_limit);
        pay_index  = r_byte_count - sld_pkg::HDR_BYTES;

        priority if (r_byte_count < sld_pkg::HDR_BYTES) begin
            code = sld_pkg::ST_SHORT;
        end else if (!n_sync_ok) begin
            code = sld_pkg::ST_BAD_SYNC;
        end else if (!len_ok) begin
            code = sld_pkg::ST_TOO_BIG;
        end else if (r_byte_count != len_limit) begin
            code = sld_pkg::ST_SIZE;
        end else if (n_xor != i_rx_byte) begin
            code = sld_pkg::ST_CHECKSUM;
        end else begin
            code = sld_pkg::ST_OK;
        end

        o_push.data.frame_cmd    = n_cmd;
        o_push.data.frame_length = n_len;
        if (i_rx_last) begin
            o_push.valid              = i_accept;
            o_push.data.kind          = sld_pkg::KIND_STATUS;
            o_push.data.payload_byte  = '0;
            o_push.data.payload_index = '0;
            o_push.data.status_code   = code;
        end else begin
            o_push.valid              = i_accept && in_payload && n_sync_ok && len_ok;
            o_push.data.kind          = sld_pkg::KIND_PAYLOAD;
            o_push.data.payload_byte  = i_rx_byte;
            o_push.data.payload_index = pay_index[sld_pkg::BYTE_W-1:0];
            o_push.data.status_code   = sld_pkg::ST_OK;
        end

        if (in_payload) begin
            n_xor = n_xor ^ i_rx_byte;
        end
        n_byte_count = (r_byte_count == sld_pkg::COUNT_MAX) ? r_byte_count
                                                             : r_byte_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= sld_pkg::SYNC_RESET;
            r_byte_count <= '0;
            r_sync_ok    <= 1'b0;
            r_cmd        <= '0;
            r_len        <= '0;
            r_xor        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sync_value <= i_cfg_wdata;
            end
            if (i_accept) begin
                if (i_rx_last) begin
                    r_byte_count <= '0;
                    r_sync_ok    <= 1'b0;
                    r_cmd        <= '0;
                    r_len        <= '0;
                    r_xor        <= '0;
                end else begin
                    r_byte_count <= n_byte_count;
                    r_sync_ok    <= n_sync_ok;
                    r_cmd        <= n_cmd;
                    r_len        <= n_len;
                    r_xor        <= n_xor;
                end
            end
        end
    end

endmodule

// ----- sv/sld_skid.sv -----
// ----------------------------------------------------------------------------
// sld_skid
// Result register with a skid stage; input side ready is registered.
// ----------------------------------------------------------------------------
module sld_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sld_pkg::t_push i_push,
    output logic           o_ready,
    sld_out_if.source      o_res
);

    logic             r_out_valid;
    logic             r_skid_valid;
    sld_pkg::t_result r_out;
    sld_pkg::t_result r_skid;

    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_push.valid;
            end
        end else if (i_push.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_res.ready) begin
            r_out <= r_skid_valid ? r_skid : i_push.data;
        end else if (i_push.valid) begin
            r_skid <= i_push.data;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_out.kind;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_index = r_out.payload_index;
    assign o_res.frame_cmd     = r_out.frame_cmd;
    assign o_res.frame_length  = r_out.frame_length;
    assign o_res.status_code   = r_out.status_code;

endmodule

// ----- sv/sync_length_xor_deframer.sv -----
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Byte-serial deframer for sync / command / length / payload / XOR frames.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle while input ready is high;
// each byte's decode is one pass of compare and XOR logic, registered in the
// result register or skid stage. A skid stage behind the result register
// keeps input ready high while one word waits downstream. Payload bytes leave
// with their index once sync and length have checked out; the byte flagged
// last yields a status word (command, length, code) and clears frame state.
// The sync value register may only be written while no byte is in flight.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sld_pkg::BYTE_W-1:0] i_cfg_wdata,
    sld_in_if.sink                     i_rx,
    sld_out_if.source                  o_res
);

    logic           rx_ready;
    logic           accept;
    sld_pkg::t_push push;

    assign i_rx.ready = rx_ready;
    assign accept     = i_rx.valid && rx_ready;

    sld_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_rx_last   (i_rx.rx_last),
        .o_push      (push)
    );

    sld_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (rx_ready),
        .o_res   (o_res)
    );

endmodule

// ----- test/sync_length_xor_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_tb
// Self-checking bench for the byte-serial sync/length/XOR deframer.
// ----------------------------------------------------------------------------
// A short table of hand-built buffers covers the status codes and the corner
// cases. Randomised buffers then follow under several sync values, mostly
// well-formed frames with random content and the rest corrupted or noise.
// Every result word is checked field by field against the table's expected
// word or an in-bench model of the deframer. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_tb;

    localparam int unsigned PAYLOAD_MAX   = 64;
    localparam int          IDLE_PCT      = 31;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          PHASE_WORDS   = 180;
    localparam int          LONG_BUFFER   = 520;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          ROWS          = 28;

    typedef struct packed {
        logic [sld_pkg::BYTE_W-1:0] b;
        logic                       last;
        logic                       fixed;
        sld_pkg::t_result           want;
    } t_row;

    // Status rows carry their word; the rest are left to the model.
    localparam t_row DIRECTED [0:ROWS-1] = '{
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h5C, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h5C, 8'h00, sld_pkg::ST_SHORT}},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h01, 8'h00, sld_pkg::ST_BAD_SYNC}},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFE, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h00, 8'h01, sld_pkg::ST_OK}},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'hFF, 8'h41, sld_pkg::ST_TOO_BIG}},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h22, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'h10, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h22, 8'h02, sld_pkg::ST_SIZE}},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h33, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h33, 8'h00, sld_pkg::ST_CHECKSUM}},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h7E, 1'b1, 1'b1,
          '{sld_pkg::KIND_STATUS, 8'h00, 8'h00, 8'h01, 8'h00, sld_pkg::ST_SIZE}}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [sld_pkg::BYTE_W-1:0] i_cfg_wdata;

    sld_in_if  rx_bus ();
    sld_out_if res_bus ();

    sync_length_xor_deframer #(
        .MAX_PAYLOAD (PAYLOAD_MAX)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_bus),
        .o_res       (res_bus)
    );

    // deframer model state
    logic [sld_pkg::BYTE_W-1:0]  sync_reg = sld_pkg::SYNC_RESET;
    logic [sld_pkg::COUNT_W-1:0] frame_pos = '0;
    logic                        sync_good = 1'b0;
    logic [sld_pkg::BYTE_W-1:0]  cap_cmd = '0;
    logic [sld_pkg::BYTE_W-1:0]  cap_len = '0;
    logic [sld_pkg::BYTE_W-1:0]  xor_sum = '0;

    sld_pkg::t_result           pending_words [$];
    logic [sld_pkg::BYTE_W-1:0] buffer_bytes [$];
    logic [sld_pkg::BYTE_W-1:0] sync_plan [5];
    sld_pkg::t_result           seen_word;
    sld_pkg::t_result           due_word;

    logic calm = 1'b0;
    int   mismatches = 0;
    int   bytes_sent = 0;
    int   buffers_sent = 0;
    int   payload_seen = 0;
    int   status_seen [6] = '{default: 0};
    int   cycle_count = 0;
    int   phase_start;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task automatic deframe_byte(input logic [sld_pkg::BYTE_W-1:0] b, input logic last,
                                output logic produced, output sld_pkg::t_result word);
        logic [sld_pkg::COUNT_W-1:0] pos;
        logic [sld_pkg::COUNT_W-1:0] csum_pos;
        logic                        len_ok;
        pos      = frame_pos;
        produced = 1'b0;
        word     = '0;
        if (pos == sld_pkg::POS_SYNC) begin
            sync_good = (b == sync_reg);
        end else if (pos == sld_pkg::POS_CMD) begin
            cap_cmd = b;
            xor_sum ^= b;
        end else if (pos == sld_pkg::POS_LEN) begin
            cap_len = b;
            xor_sum ^= b;
        end
        len_ok   = (cap_len <= PAYLOAD_MAX);
        csum_pos = sld_pkg::HDR_BYTES + {1'b0, cap_len};
        if (last) begin
            produced          = 1'b1;
            word.kind         = sld_pkg::KIND_STATUS;
            word.frame_cmd    = cap_cmd;
            word.frame_length = cap_len;
            if (pos < sld_pkg::HDR_BYTES) word.status_code = sld_pkg::ST_SHORT;
            else if (!sync_good)          word.status_code = sld_pkg::ST_BAD_SYNC;
            else if (!len_ok)             word.status_code = sld_pkg::ST_TOO_BIG;
            else if (pos != csum_pos)     word.status_code = sld_pkg::ST_SIZE;
            else if (xor_sum != b)        word.status_code = sld_pkg::ST_CHECKSUM;
            else                          word.status_code = sld_pkg::ST_OK;
            frame_pos = '0;
            sync_good = 1'b0;
            cap_cmd   = '0;
            cap_len   = '0;
            xor_sum   = '0;
        end else begin
            if (pos >= sld_pkg::HDR_BYTES && pos < csum_pos) begin
                xor_sum ^= b;
                if (sync_good && len_ok) begin
                    produced           = 1'b1;
                    word.kind          = sld_pkg::KIND_PAYLOAD;
                    word.payload_byte  = b;
                    word.payload_index = 8'(pos - sld_pkg::HDR_BYTES);
                    word.frame_cmd     = cap_cmd;
                    word.frame_length  = cap_len;
                end
            end
            if (frame_pos != sld_pkg::COUNT_MAX) frame_pos = frame_pos + 1'b1;
        end
    endtask

    task automatic send_byte(input logic [sld_pkg::BYTE_W-1:0] b, input logic last,
                             input logic fixed, input sld_pkg::t_result want);
        logic             produced;
        sld_pkg::t_result word;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            rx_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        rx_bus.rx_last <= last;
        do @(posedge i_clk); while (!rx_bus.ready);
        bytes_sent++;
        deframe_byte(b, last, produced, word);
        if (fixed) pending_words.push_back(want);
        else if (produced) pending_words.push_back(word);
    endtask

    task automatic send_buffer();
        foreach (buffer_bytes[i])
            send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1, 1'b0, '0);
        buffers_sent++;
    endtask

    task automatic make_buffer();
        int                         pick;
        int                         r;
        int                         len;
        int                         body;
        logic [sld_pkg::BYTE_W-1:0] chk;
        logic [sld_pkg::BYTE_W-1:0] v;
        buffer_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            repeat ($urandom_range(1, 8)) buffer_bytes.push_back(8'($urandom));
        end else begin
            r = $urandom_range(0, 19);
            if (pick >= 85)  len = $urandom_range(PAYLOAD_MAX + 1, 255);
            else if (r == 0) len = PAYLOAD_MAX;
            else if (r < 4)  len = $urandom_range(13, PAYLOAD_MAX);
            else             len = $urandom_range(0, 12);
            if (pick >= 78 && pick < 85)
                buffer_bytes.push_back(sync_reg ^ 8'($urandom_range(1, 255)));
            else
                buffer_bytes.push_back(sync_reg);
            v = 8'($urandom);
            buffer_bytes.push_back(v);
            chk = v ^ 8'(len);
            buffer_bytes.push_back(8'(len));
            body = (pick >= 85) ? $urandom_range(0, 6) : len;
            repeat (body) begin
                v = 8'($urandom);
                chk ^= v;
                buffer_bytes.push_back(v);
            end
            if (pick >= 60 && pick < 70) chk ^= 8'($urandom_range(1, 255));
            buffer_bytes.push_back(chk);
            if (pick >= 70 && pick < 78) begin
                if ($urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 3)) buffer_bytes.push_back(8'($urandom));
                else
                    repeat ($urandom_range(1, buffer_bytes.size() - 1))
                        void'(buffer_bytes.pop_back());
            end
        end
    endtask

    task automatic write_sync(input logic [sld_pkg::BYTE_W-1:0] value);
        rx_bus.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sync_reg = value;
    endtask

    task automatic check_word(input sld_pkg::t_result got, input sld_pkg::t_result want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("result_kind got %h want %h", got.kind, want.kind));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte got %h want %h",
                                      got.payload_byte, want.payload_byte));
        if (got.payload_index !== want.payload_index)
            report_mismatch($sformatf("payload_index got %h want %h",
                                      got.payload_index, want.payload_index));
        if (got.frame_cmd !== want.frame_cmd)
            report_mismatch($sformatf("frame_cmd got %h want %h",
                                      got.frame_cmd, want.frame_cmd));
        if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length got %h want %h",
                                      got.frame_length, want.frame_length));
        if (got.status_code !== want.status_code)
            report_mismatch($sformatf("status_code got %h want %h",
                                      got.status_code, want.status_code));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            seen_word.kind          = sld_pkg::t_kind'(res_bus.result_kind);
            seen_word.payload_byte  = res_bus.payload_byte;
            seen_word.payload_index = res_bus.payload_index;
            seen_word.frame_cmd     = res_bus.frame_cmd;
            seen_word.frame_length  = res_bus.frame_length;
            seen_word.status_code   = sld_pkg::t_status'(res_bus.status_code);
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word with nothing pending: %h", seen_word));
            end else begin
                due_word = pending_words.pop_front();
                check_word(seen_word, due_word);
                if (due_word.kind == sld_pkg::KIND_STATUS)
                    status_seen[int'(due_word.status_code)]++;
                else
                    payload_seen++;
            end
        end
        res_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        rx_bus.valid   <= 1'b0;
        rx_bus.rx_byte <= '0;
        rx_bus.rx_last <= 1'b0;
        sync_plan[0] = 8'h00;
        sync_plan[1] = 8'hFF;
        for (int k = 2; k < 5; k++) sync_plan[k] = 8'($urandom);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < ROWS; k++)
            send_byte(DIRECTED[k].b, DIRECTED[k].last, DIRECTED[k].fixed, DIRECTED[k].want);
        buffers_sent += 7;

        for (int phase = 0; phase < 5; phase++) begin
            write_sync(sync_plan[phase]);
            calm = (phase == 1);
            phase_start = bytes_sent;
            if (phase == 2) begin
                // count saturates before the last byte
                buffer_bytes.delete();
                buffer_bytes.push_back(sync_reg);
                repeat (LONG_BUFFER - 1) buffer_bytes.push_back(8'($urandom_range(0, 64)));
                send_buffer();
            end
            while (bytes_sent - phase_start < PHASE_WORDS) begin
                make_buffer();
                send_buffer();
            end
        end
        calm = 1'b0;

        rx_bus.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers under 6 sync values; checked %0d payload words",
                 bytes_sent, buffers_sent, payload_seen);
        $display("Status words ok/short/sync/big/size/checksum: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sync_length_xor_deframer.f -----
sv/sld_pkg.sv
sv/sld_in_if.sv
sv/sld_out_if.sv
sv/sld_core.sv
sv/sld_skid.sv
sv/sync_length_xor_deframer.sv
test/sync_length_xor_deframer_tb.sv
